@@ rtl/core/ssi_pkg.sv @@
package ssi_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_DUMP   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_FULL      = 3'd2,
    STS_CLEARED   = 3'd3,
    STS_ENTRY     = 3'd4,
    STS_EMPTY     = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    clr;
    logic                    rot;
    logic signed [VAL_W-1:0] key;
  } cell_ctl_t;

endpackage

@@ rtl/core/ssi_in_if.sv @@
interface ssi_in_if;
  import ssi_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic signed [VAL_W-1:0]     value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

@@ rtl/core/ssi_out_if.sv @@
interface ssi_out_if;
  import ssi_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [IDX_W-1:0]            position;
  logic signed [VAL_W-1:0]     entry_value;
  logic                        last;

  modport source (output valid, output status, output position, output entry_value,
                  output last, input ready);
  modport sink   (input valid, input status, input position, input entry_value,
                  input last, output ready);
endinterface

@@ rtl/core/ssi_cell.sv @@
module ssi_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  ssi_pkg::cell_ctl_t              ctl,
  input  logic                            left_valid,
  input  logic                            left_lt,
  input  logic signed [ssi_pkg::VAL_W-1:0] left_val,
  input  logic                            right_valid,
  input  logic signed [ssi_pkg::VAL_W-1:0] right_val,
  input  logic signed [ssi_pkg::VAL_W-1:0] head_val,
  output logic signed [ssi_pkg::VAL_W-1:0] val,
  output logic                            valid,
  output logic                            lt,
  output logic                            eq
);
  import ssi_pkg::*;

  // Compare the held entry against the broadcast key
  assign lt = valid && (val < ctl.key);
  assign eq = valid && (val == ctl.key);

  // Valid bit: insert shifts the fill boundary right by one, clear drops it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins && !lt) begin
      valid <= left_valid;
    end
  end

  // Entry: take the key at the insert point, the left entry above it,
  // or rotate toward the head while dumping
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      val <= left_lt ? ctl.key : left_val;
    end else if (ctl.rot && valid) begin
      val <= right_valid ? right_val : head_val;
    end
  end

endmodule

@@ rtl/core/sorted_set_insert_top.sv @@
// Sorted set of distinct signed 32-bit values, held in a chain of cells.
// Channel req (valid/ready) carries func and value; channel rsp carries
// status, position, entry_value and last. A word moves when valid and
// ready are both high at a rising clk edge.
// Insert: every cell compares against the value at once and the chain
// shifts in the same cycle; one result word (inserted, duplicate or full)
// is registered and shown in the cycle after the request word is taken.
// Clear: one result word. Unused func code 3 is taken and dropped with
// no result.
// Dump: the valid cells rotate toward cell 0 once per result word, so a
// table of n entries gives n words (one empty word if n is 0). For a
// nonempty table the sequencer first enters its dump state, then
// registers the words one by one, last marking the final one; the
// rotation leaves the table as it was. While a dump runs req.ready is
// low; an insert or clear changes the table when its word is taken.
// A single output register parts the two sides: a new request is taken
// in the cycle the waiting result is taken. If rsp.ready stays low the
// result holds and the block stalls; no word is lost.
// Reset (rst, synchronous, active high) empties the table and the output.
module sorted_set_insert_top (
  input  logic      clk,
  input  logic      rst,
  ssi_in_if.sink    req,
  ssi_out_if.source rsp
);
  import ssi_pkg::*;

  state_t                  state, state_next;
  cell_ctl_t               ctl;
  logic [CNT_W-1:0]        count, count_next;
  logic [IDX_W-1:0]        idx, idx_next;

  logic signed [VAL_W-1:0] cell_val   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cell_valid;
  logic [TABLE_DEPTH-1:0]  cell_lt;
  logic [TABLE_DEPTH-1:0]  cell_eq;
  logic [TABLE_DEPTH-1:0]  boundary;

  logic                    slot_free;
  logic                    take;
  logic                    load;
  logic                    dup;
  logic                    full;
  logic [IDX_W-1:0]        ins_pos;

  logic                    rsp_valid;
  logic [STATUS_W-1:0]     rsp_status, rsp_status_next;
  logic [IDX_W-1:0]        rsp_position, rsp_position_next;
  logic signed [VAL_W-1:0] rsp_entry_value, rsp_entry_value_next;
  logic                    rsp_last, rsp_last_next;

  // Chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                    lv, llt, rv;
    logic signed [VAL_W-1:0] lval, rval;

    if (i == 0) begin : g_head
      assign lv   = 1'b1;
      assign llt  = 1'b1;
      assign lval = '0;
    end else begin : g_body
      assign lv   = cell_valid[i-1];
      assign llt  = cell_lt[i-1];
      assign lval = cell_val[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_next
      assign rv   = cell_valid[i+1];
      assign rval = cell_val[i+1];
    end

    assign boundary[i] = llt && !cell_lt[i];

    ssi_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_lt     (llt),
      .left_val    (lval),
      .right_valid (rv),
      .right_val   (rval),
      .head_val    (cell_val[0]),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // Encode the one-hot insert point
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (boundary[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  assign dup       = |cell_eq;
  assign full      = cell_valid[TABLE_DEPTH-1];
  assign slot_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && slot_free;
  assign take      = req.valid && req.ready;

  // Sequencer: next state, cell command and result word
  always_comb begin
    state_next           = state;
    count_next           = count;
    idx_next             = idx;
    ctl.ins              = 1'b0;
    ctl.clr              = 1'b0;
    ctl.rot              = 1'b0;
    ctl.key              = req.value;
    load                 = 1'b0;
    rsp_status_next      = STS_INSERTED;
    rsp_position_next    = '0;
    rsp_entry_value_next = '0;
    rsp_last_next        = 1'b1;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (req.func)
            FN_INSERT: begin
              load = 1'b1;
              if (dup) begin
                rsp_status_next   = STS_DUPLICATE;
                rsp_position_next = ins_pos;
              end else if (full) begin
                rsp_status_next = STS_FULL;
              end else begin
                ctl.ins           = 1'b1;
                count_next        = count + 1'b1;
                rsp_position_next = ins_pos;
              end
            end
            FN_CLEAR: begin
              load            = 1'b1;
              ctl.clr         = 1'b1;
              count_next      = '0;
              rsp_status_next = STS_CLEARED;
            end
            FN_DUMP: begin
              if (count == '0) begin
                load            = 1'b1;
                rsp_status_next = STS_EMPTY;
              end else begin
                state_next = ST_DUMP;
                idx_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          load                 = 1'b1;
          ctl.rot              = 1'b1;
          rsp_status_next      = STS_ENTRY;
          rsp_position_next    = idx;
          rsp_entry_value_next = cell_val[0];
          rsp_last_next        = (CNT_W'(idx) + 1'b1) == count;
          idx_next             = idx + 1'b1;
          if (rsp_last_next) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status      <= rsp_status_next;
      rsp_position    <= rsp_position_next;
      rsp_entry_value <= rsp_entry_value_next;
      rsp_last        <= rsp_last_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.position    = rsp_position;
  assign rsp.entry_value = rsp_entry_value;
  assign rsp.last        = rsp_last;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == count)
    else $error("entry count disagrees with cell valid bits");

  a_dup_keeps_table: assert property (@(posedge clk) disable iff (rst)
    take && (req.func == FN_INSERT) && dup |=> count == $past(count))
    else $error("duplicate insert changed the table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    take && (req.func == FN_INSERT) && !dup && !full |=>
    count == $past(count) + 1'b1)
    else $error("accepted insert did not add one entry");

  a_dump_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> !take && (count != '0))
    else $error("request taken or table empty during dump");
`endif

endmodule
